// File: src/lext_pkg.sv
// shared types, codes and sizes for the logic expression tokenizer
`timescale 1ns / 1ps

package lext_pkg;

  localparam int ID_BITS    = 32;
  localparam int MAX_DEPTH  = 255;
  localparam int DEPTH_BITS = $clog2(MAX_DEPTH + 1);
  localparam int NUM_W      = 32;
  localparam int ACC_EXT    = ID_BITS + 4;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);
  localparam int OUT_DATA_W = 40;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_OR    = 8'h7c;
  localparam logic [7:0] CH_AND   = 8'h26;
  localparam logic [7:0] CH_NOT   = 8'h7e;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [2:0] {
    KIND_ID    = 3'd0,
    KIND_OPEN  = 3'd1,
    KIND_CLOSE = 3'd2,
    KIND_OR    = 3'd3,
    KIND_AND   = 3'd4,
    KIND_NOT   = 3'd5,
    KIND_TRUE  = 3'd6,
    KIND_END   = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE  = 3'd0,
    ERR_CLOSE = 3'd1,
    ERR_CHAR  = 3'd2,
    ERR_OPEN  = 3'd3,
    ERR_NUM   = 3'd4,
    ERR_DEPTH = 3'd5
  } err_t;

  typedef struct packed {
    kind_t            kind;
    logic [NUM_W-1:0] number;
    err_t             err;
  } token_t;

  typedef struct packed {
    logic [1:0] count;
    token_t     first;
    token_t     second;
  } push_t;

  typedef struct packed {
    token_t tok;
    logic   last;
  } result_t;

endpackage

// File: src/lext_step.sv
// tokenizer state and per-character decode
`timescale 1ns / 1ps

module lext_step (
  input  logic          clk,
  input  logic          rst,
  input  logic          fire,
  input  logic [7:0]    character,
  input  logic          end_marker,
  output lext_pkg::push_t push
);
  import lext_pkg::*;

  logic [ID_BITS-1:0]    acc;
  logic                  reading;
  logic [DEPTH_BITS-1:0] depth;
  logic                  err_l;

  logic [ID_BITS-1:0]    acc_next;
  logic                  reading_next;
  logic [DEPTH_BITS-1:0] depth_next;
  logic                  err_l_next;

  logic                  is_digit;
  logic [3:0]            digit;
  logic [ACC_EXT-1:0]    acc_ext;
  logic [ACC_EXT-1:0]    prod;
  logic                  overflow;
  logic                  flush;
  logic                  tok_valid;
  token_t                tok;
  token_t                num_tok;

  assign is_digit = (character >= CH_ZERO) && (character <= CH_NINE);
  assign digit    = 4'(character - CH_ZERO);
  assign acc_ext  = reading ? ACC_EXT'(acc) : '0;
  assign prod     = (acc_ext << 3) + (acc_ext << 1) + ACC_EXT'(digit);
  assign overflow = |prod[ACC_EXT-1:ID_BITS];

  assign num_tok.kind   = KIND_ID;
  assign num_tok.number = NUM_W'(acc);
  assign num_tok.err    = ERR_NONE;

  always_comb begin
    acc_next     = acc;
    reading_next = reading;
    depth_next   = depth;
    err_l_next   = err_l;
    flush        = 1'b0;
    tok_valid    = 1'b0;
    tok.kind     = KIND_END;
    tok.number   = '0;
    tok.err      = ERR_NONE;
    if (end_marker) begin
      if (!err_l) begin
        flush     = reading;
        tok_valid = 1'b1;
        tok.err   = (depth != '0) ? ERR_OPEN : ERR_NONE;
      end
      acc_next     = '0;
      reading_next = 1'b0;
      depth_next   = '0;
      err_l_next   = 1'b0;
    end else if (err_l) begin
      // swallow everything until the end beat
    end else if (is_digit) begin
      if (overflow) begin
        tok_valid    = 1'b1;
        tok.err      = ERR_NUM;
        err_l_next   = 1'b1;
        reading_next = 1'b0;
        acc_next     = '0;
      end else begin
        acc_next     = prod[ID_BITS-1:0];
        reading_next = 1'b1;
      end
    end else begin
      flush = reading;
      if (reading) begin
        reading_next = 1'b0;
        acc_next     = '0;
      end
      case (character)
        CH_OPEN: begin
          tok_valid = 1'b1;
          if (depth >= DEPTH_BITS'(MAX_DEPTH)) begin
            tok.err    = ERR_DEPTH;
            err_l_next = 1'b1;
          end else begin
            tok.kind   = KIND_OPEN;
            depth_next = depth + 1'b1;
          end
        end
        CH_CLOSE: begin
          tok_valid = 1'b1;
          if (depth == '0) begin
            tok.err    = ERR_CLOSE;
            err_l_next = 1'b1;
          end else begin
            tok.kind   = KIND_CLOSE;
            depth_next = depth - 1'b1;
          end
        end
        CH_OR: begin
          tok_valid = 1'b1;
          tok.kind  = KIND_OR;
        end
        CH_AND: begin
          tok_valid = 1'b1;
          tok.kind  = KIND_AND;
        end
        CH_NOT: begin
          tok_valid = 1'b1;
          tok.kind  = KIND_NOT;
        end
        CH_STAR: begin
          tok_valid = 1'b1;
          tok.kind  = KIND_TRUE;
        end
        CH_SPACE: begin
          tok_valid = 1'b0;
        end
        default: begin
          tok_valid  = 1'b1;
          tok.err    = ERR_CHAR;
          err_l_next = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    push.second = tok;
    if (flush) begin
      push.first = num_tok;
    end else begin
      push.first = tok;
    end
    if (fire) begin
      push.count = 2'(flush) + 2'(tok_valid);
    end else begin
      push.count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc     <= '0;
      reading <= 1'b0;
      depth   <= '0;
      err_l   <= 1'b0;
    end else if (fire) begin
      acc     <= acc_next;
      reading <= reading_next;
      depth   <= depth_next;
      err_l   <= err_l_next;
    end
  end

endmodule

// File: src/lext_queue.sv
// small result queue taking up to two tokens per beat
`timescale 1ns / 1ps

module lext_queue (
  input  logic                clk,
  input  logic                rst,
  input  lext_pkg::push_t     push,
  output logic                room,
  output logic                out_valid,
  input  logic                out_ready,
  output lext_pkg::result_t   out_result
);
  import lext_pkg::*;

  result_t              mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_CNT_W-1:0]   count;
  logic                 pop;
  logic [Q_PTR_W-1:0]   wr_ptr_p1;

  assign room       = count <= Q_CNT_W'(Q_DEPTH - 2);
  assign out_valid  = count != '0;
  assign out_result = mem[rd_ptr];
  assign pop        = out_valid && out_ready;
  assign wr_ptr_p1  = wr_ptr + 1'b1;

  always_ff @(posedge clk) begin
    case (push.count)
      2'd1: begin
        mem[wr_ptr] <= '{tok: push.first, last: 1'b1};
      end
      2'd2: begin
        mem[wr_ptr]    <= '{tok: push.first, last: 1'b0};
        mem[wr_ptr_p1] <= '{tok: push.second, last: 1'b1};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + Q_PTR_W'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + Q_CNT_W'(push.count) - Q_CNT_W'(pop);
    end
  end

endmodule

// File: src/logic_expression_tokenizer_core.sv
// top level of the logic expression tokenizer
//
// input stream: one character per beat in s_axis_tdata; a beat with
// s_axis_tlast high ends the string and its character is ignored.
// output stream: one token per beat; m_axis_tlast marks the final token
// caused by an input beat. an input beat gives zero, one or two tokens.
// a character is decoded in the cycle it is taken and its tokens are
// registered in the token queue, which drives the output.
// throughput is one input beat per cycle while the receiver is ready and
// each beat yields at most one token; a beat with two tokens (number then
// operator) sends them out one by one through the queue's single port.
// the four-entry token queue keeps s_axis_tready high while at least two
// entries are free, so input keeps flowing while a token waits.
// when the receiver stalls, the queue fills and s_axis_tready drops;
// no token is lost or repeated.
// rst (synchronous) empties the queue and clears the number, the
// parenthesis depth and any latched error.
`timescale 1ns / 1ps

module logic_expression_tokenizer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // character
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // surface_number, error_code, zero pad
  output logic [2:0]  m_axis_tuser,   // token_kind
  output logic        m_axis_tlast
);
  import lext_pkg::*;

  logic    fire;
  logic    room;
  push_t   push;
  result_t head;

  assign s_axis_tready = room;
  assign fire          = s_axis_tvalid && room;

  lext_step u_step (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .character  (s_axis_tdata),
    .end_marker (s_axis_tlast),
    .push       (push)
  );

  lext_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .room       (room),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_result (head)
  );

  assign m_axis_tdata = OUT_DATA_W'({head.tok.err, head.tok.number});
  assign m_axis_tuser = head.tok.kind;
  assign m_axis_tlast = head.last;

endmodule
